// ----- rtl/axd_pkg.sv -----
package axd_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] blk_t;
    typedef logic [255:0] key_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TKEXP,
        ST_TENC,
        ST_TDBL,
        ST_DKEXP,
        ST_DDEC,
        ST_OUT
    } state_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DK0 = 3'd0;
    localparam logic [2:0] REG_TK3 = 3'd7;

    localparam logic [7:0] GF_POLY = 8'h87;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam byte_t RCON [8] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80};

    // Inverse S-box by search over the forward table.
    function automatic byte_t inv_sbox(input byte_t v);
        byte_t r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic byte_t xt(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // State byte i sits at bits 8i+7:8i.
    function automatic byte_t gb(input blk_t s, input int i);
        return s[8*i +: 8];
    endfunction

endpackage

// ----- rtl/axd_keyexp.sv -----
// Key schedule: produces one 128-bit round key per step, forward or backward.
module axd_keyexp (
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic fwd_step,
    input  logic bwd_step,
    input  axd_pkg::key_t key,
    output axd_pkg::blk_t rk_lo,
    output axd_pkg::blk_t rk_hi
);
    import axd_pkg::*;

    // Window holds words w[4j..4j+7], word 0 in bits 255:224.
    key_t win_reg;
    logic [2:0] rc_reg;
    key_t win_next;
    logic [2:0] rc_next;
    logic [2:0] rc_m1;

    function automatic logic [31:0] subw(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic blk_t tobytes(input logic [127:0] w);
        blk_t b;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                b[8*(4*c+k) +: 8] = w[127-32*c-8*k -: 8];
            end
        end
        return b;
    endfunction

    logic [31:0] w [8];
    logic [31:0] n [4];
    logic [31:0] p [4];
    logic odd_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++) begin
            w[i] = win_reg[255-32*i -: 32];
        end
        rc_m1 = rc_reg - 3'd1;
        // Forward: next four words.
        n[0] = w[0] ^ (odd_reg ? subw(w[7])
                : (subw({w[7][23:0], w[7][31:24]}) ^ {RCON[rc_reg], 24'h0}));
        n[1] = w[1] ^ n[0];
        n[2] = w[2] ^ n[1];
        n[3] = w[3] ^ n[2];
        // Backward: previous four words. When the group being removed used a round
        // constant, it was the one below the current count.
        p[3] = w[7] ^ w[6];
        p[2] = w[6] ^ w[5];
        p[1] = w[5] ^ w[4];
        p[0] = w[4] ^ (odd_reg ? (subw({w[3][23:0], w[3][31:24]}) ^ {RCON[rc_m1], 24'h0})
                : subw(w[3]));
        win_next = win_reg;
        rc_next = rc_reg;
        if (load) begin
            win_next = key;
            rc_next = 3'd0;
        end else if (fwd_step) begin
            win_next = {win_reg[127:0], n[0], n[1], n[2], n[3]};
            if (!odd_reg) begin
                rc_next = rc_reg + 3'd1;
            end
        end else if (bwd_step) begin
            win_next = {p[0], p[1], p[2], p[3], win_reg[255:128]};
            if (odd_reg) begin
                rc_next = rc_reg - 3'd1;
            end
        end
    end

    // odd_reg marks that the next forward word group uses plain SubWord.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            odd_reg <= 1'b0;
        end else if (load) begin
            odd_reg <= 1'b0;
        end else if (fwd_step || bwd_step) begin
            odd_reg <= ~odd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        rc_reg <= rc_next;
    end

    // Round keys j and j+1 of the current window.
    assign rk_lo = tobytes(win_reg[255:128]);
    assign rk_hi = tobytes(win_reg[127:0]);
endmodule

// ----- rtl/axd_round.sv -----
// Shared round unit: one AES encrypt or decrypt round per cycle.
module axd_round (
    input  axd_pkg::blk_t s,
    input  axd_pkg::blk_t rk,
    input  logic dec,
    input  logic last,
    output axd_pkg::blk_t r
);
    import axd_pkg::*;

    blk_t a, b, m;
    byte_t x0, x1, x2, x3, y1, y2;

    always_comb
    begin
        a = '0;
        b = '0;
        m = '0;
        x0 = '0;
        x1 = '0;
        x2 = '0;
        x3 = '0;
        y1 = '0;
        y2 = '0;
        if (!dec) begin
            // SubBytes and ShiftRows.
            for (int rr = 0; rr < 4; rr++) begin
                for (int c = 0; c < 4; c++) begin
                    a[8*(rr+4*c) +: 8] = SBOX[s[8*(rr+4*((c+rr)%4)) +: 8]];
                end
            end
            for (int c = 0; c < 4; c++) begin
                x0 = a[8*(4*c) +: 8];
                x1 = a[8*(4*c+1) +: 8];
                x2 = a[8*(4*c+2) +: 8];
                x3 = a[8*(4*c+3) +: 8];
                m[8*(4*c) +: 8] = xt(x0) ^ xt(x1) ^ x1 ^ x2 ^ x3;
                m[8*(4*c+1) +: 8] = x0 ^ xt(x1) ^ xt(x2) ^ x2 ^ x3;
                m[8*(4*c+2) +: 8] = x0 ^ x1 ^ xt(x2) ^ xt(x3) ^ x3;
                m[8*(4*c+3) +: 8] = xt(x0) ^ x0 ^ x1 ^ x2 ^ xt(x3);
            end
            r = (last ? a : m) ^ rk;
        end else begin
            // AddRoundKey, InvMixColumns unless last, InvShiftRows, InvSubBytes.
            a = s ^ rk;
            m = a;
            if (!last) begin
                for (int c = 0; c < 4; c++) begin
                    x0 = a[8*(4*c) +: 8];
                    x1 = a[8*(4*c+1) +: 8];
                    x2 = a[8*(4*c+2) +: 8];
                    x3 = a[8*(4*c+3) +: 8];
                    y1 = xt(x0 ^ x2);
                    y2 = xt(x1 ^ x3);
                    y1 = xt(y1);
                    y2 = xt(y2);
                    // Fold 0E/0B/0D/09 into 02/03/01/01 plus correction.
                    x0 = x0 ^ y1;
                    x1 = x1 ^ y2;
                    x2 = x2 ^ y1;
                    x3 = x3 ^ y2;
                    m[8*(4*c) +: 8] = xt(x0) ^ xt(x1) ^ x1 ^ x2 ^ x3;
                    m[8*(4*c+1) +: 8] = x0 ^ xt(x1) ^ xt(x2) ^ x2 ^ x3;
                    m[8*(4*c+2) +: 8] = x0 ^ x1 ^ xt(x2) ^ xt(x3) ^ x3;
                    m[8*(4*c+3) +: 8] = xt(x0) ^ x0 ^ x1 ^ x2 ^ xt(x3);
                end
            end
            for (int rr = 0; rr < 4; rr++) begin
                for (int c = 0; c < 4; c++) begin
                    b[8*(rr+4*((c+rr)%4)) +: 8] = inv_sbox(m[8*(rr+4*c) +: 8]);
                end
            end
            r = b;
        end
    end
endmodule

// ----- rtl/aes256_xts_block_decrypt.sv -----
// Sequence: from an input transaction the block runs the tweak encrypt rounds, the tweak
// doubling steps, the data key schedule and the decrypt rounds in turn; the tweak and
// decrypt rounds share one round unit, and both keys share one key schedule unit.
// One item at a time: in_stall stays high from the input transaction until the result
// is taken.
// Reset: rst_n asynchronous, clears control and all key registers to zero.
module aes256_xts_block_decrypt #(
    parameter int ROUNDS = 14,
    parameter int BLOCKS_PER_SECTOR = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [31:0] sector,
    input  logic [4:0] block_pos,
    input  logic [63:0] cipher_low,
    input  logic [63:0] cipher_high,
    output logic out_valid,
    input  logic out_stall,
    output logic [63:0] plain_low,
    output logic [63:0] plain_high
);
    import axd_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);
    localparam int BW = $clog2(BLOCKS_PER_SECTOR + 1) > 5 ? $clog2(BLOCKS_PER_SECTOR + 1) : 5;

    logic [63:0] key_reg [8];
    state_t state_reg, state_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    logic [BW-1:0] dbl_reg;
    blk_t tw_reg, st_reg, ct_reg;

    // Configuration writes.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 8; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && cfg_index >= REG_DK0 && cfg_index <= REG_TK3) begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    logic accept, load, fwd, bwd;
    logic [255:0] kmux;
    blk_t rk_lo, rk_hi, rk, rin, rout;
    logic rdec, rlast;

    assign accept = in_valid && !in_stall;

    axd_keyexp u_kx (
        .clk(clk), .rst_n(rst_n), .load(load), .fwd_step(fwd), .bwd_step(bwd),
        .key(kmux), .rk_lo(rk_lo), .rk_hi(rk_hi)
    );

    axd_round u_rd (.s(rin), .rk(rk), .dec(rdec), .last(rlast), .r(rout));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = ST_TENC;
                    cnt_next = '0;
                end
            end
            ST_TENC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RW'(ROUNDS)) begin
                    state_next = ST_TDBL;
                end
            end
            ST_TDBL:
            begin
                if (dbl_reg == '0) begin
                    state_next = ST_DKEXP;
                    cnt_next = '0;
                end
            end
            ST_DKEXP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RW'(ROUNDS - 1)) begin
                    state_next = ST_DDEC;
                    cnt_next = RW'(ROUNDS);
                end
            end
            ST_DDEC:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Key unit and round unit control.
    always_comb
    begin
        load = 1'b0;
        fwd = 1'b0;
        bwd = 1'b0;
        kmux = {key_reg[4], key_reg[5], key_reg[6], key_reg[7]};
        rk = rk_lo;
        rin = st_reg;
        rdec = 1'b0;
        rlast = 1'b0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                load = 1'b1;
            end
            ST_TENC:
            begin
                // Round 0 takes the low half; round cnt then finds its key in the
                // high half as the window steps once per round.
                rk = (cnt_reg == '0) ? rk_lo : rk_hi;
                rlast = (cnt_reg == RW'(ROUNDS));
                fwd = (cnt_reg != '0);
            end
            ST_TDBL:
            begin
                load = (dbl_reg == '0);
                kmux = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
            end
            ST_DKEXP:
            begin
                fwd = (cnt_reg < RW'(ROUNDS - 1));
            end
            ST_DDEC:
            begin
                // The last round key sits in the high half; below it the window
                // steps back once per round and the key is in the low half.
                rk = (cnt_reg == RW'(ROUNDS)) ? rk_hi : rk_lo;
                rdec = 1'b1;
                rlast = (cnt_reg == RW'(ROUNDS));
                bwd = (cnt_reg != RW'(ROUNDS)) && (cnt_reg != '0);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            dbl_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (accept) begin
                dbl_reg <= BW'(block_pos);
            end else if (state_reg == ST_TDBL && dbl_reg != '0) begin
                dbl_reg <= dbl_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            st_reg <= {64'h0, {32{sector[31]}}, sector};
            ct_reg <= {cipher_high, cipher_low};
        end else if (state_reg == ST_TENC) begin
            st_reg <= (cnt_reg == '0) ? (st_reg ^ rk_lo) : rout;
        end else if (state_reg == ST_TDBL) begin
            if (dbl_reg != '0) begin
                st_reg <= {st_reg[126:0], 1'b0} ^ (st_reg[127] ? {120'h0, GF_POLY} : '0);
            end else begin
                tw_reg <= st_reg;
            end
        end else if (state_reg == ST_DKEXP && cnt_reg == RW'(ROUNDS - 1)) begin
            st_reg <= ct_reg ^ tw_reg;
        end else if (state_reg == ST_DDEC) begin
            st_reg <= (cnt_reg == '0) ? (st_reg ^ rk_lo ^ tw_reg) : rout;
        end
    end

    assign out_valid = (state_reg == ST_OUT);
    assign plain_low = st_reg[63:0];
    assign plain_high = st_reg[127:64];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken with result pending");
    a_go: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result without work");
`endif
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import axd_pkg::*;

    localparam int ROUNDS = 14;
    localparam int SETTLE_CYCLES = 3 * ROUNDS + 31 + 9 + 20;
    localparam int CYCLE_LIMIT = 1500000;

    typedef logic [63:0] key_words_t [4];
    typedef blk_t round_keys_t [15];

    typedef struct {
        logic [31:0] sector;
        logic [4:0]  bidx;
        logic [63:0] lo;
        logic [63:0] hi;
    } cipher_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;

    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] sector = '0;
    logic [4:0] block_pos = '0;
    logic [63:0] cipher_low = '0;
    logic [63:0] cipher_high = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [63:0] plain_low;
    logic [63:0] plain_high;

    // Mirror of the key registers and the inverse S-box built at start.
    key_words_t data_key;
    key_words_t tweak_key;
    byte_t inv_sb [256];

    cipher_item_t pending_blocks [$];
    blk_t expected_plain [$];

    int n_sent = 0;
    int n_done = 0;
    int fails = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int cycles = 0;
    logic no_idle = 1'b0;
    logic rx_hold = 1'b0;

    aes256_xts_block_decrypt #(.ROUNDS(ROUNDS), .BLOCKS_PER_SECTOR(32)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sector(sector), .block_pos(block_pos),
        .cipher_low(cipher_low), .cipher_high(cipher_high),
        .out_valid(out_valid), .out_stall(out_stall),
        .plain_low(plain_low), .plain_high(plain_high)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // GF(2^8) multiply with the AES polynomial.
    function automatic byte_t gf8_mul(byte_t a, byte_t b);
        byte_t acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    function automatic blk_t sub_bytes(blk_t s, bit inverse);
        for (int i = 0; i < 16; i++)
            s[8*i +: 8] = inverse ? inv_sb[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
        return s;
    endfunction

    // Byte r + 4c holds row r of column c.
    function automatic blk_t shift_rows(blk_t s, bit inverse);
        blk_t t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                if (inverse) t[8*(r + 4*((c + r) & 3)) +: 8] = s[8*(r + 4*c) +: 8];
                else t[8*(r + 4*c) +: 8] = s[8*(r + 4*((c + r) & 3)) +: 8];
            end
        return t;
    endfunction

    function automatic blk_t mix_columns(blk_t s, bit inverse);
        byte_t coef [4];
        blk_t t;
        byte_t v;
        if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf8_mul(s[8*(4*c + k) +: 8], coef[(k - r + 4) & 3]);
                t[8*(4*c + r) +: 8] = v;
            end
        return t;
    endfunction

    // AES-256 key schedule; key byte 0 is the top byte of word 0.
    function automatic round_keys_t expand_key(key_words_t kw);
        logic [31:0] w [60];
        logic [31:0] t;
        round_keys_t rk;
        for (int i = 0; i < 8; i++)
            w[i] = (i & 1) ? kw[i >> 1][31:0] : kw[i >> 1][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i - 1];
            if ((i & 7) == 0)
                t = {t[23:0], t[31:24]};
            if ((i & 7) == 0 || (i & 7) == 4)
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            if ((i & 7) == 0)
                t[31:24] ^= 8'h01 << ((i >> 3) - 1);
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    rk[r][8*(4*c + j) +: 8] = w[4*r + c][31 - 8*j -: 8];
        return rk;
    endfunction

    // Plaintext for one block: tweak from the sector, doubled, then XTS decrypt.
    function automatic blk_t xts_plaintext(cipher_item_t it);
        round_keys_t trk;
        round_keys_t drk;
        blk_t tw;
        blk_t s;
        logic carry;
        trk = expand_key(tweak_key);
        drk = expand_key(data_key);

        tw = {64'h0, {32{it.sector[31]}}, it.sector};
        tw ^= trk[0];
        for (int r = 1; r < ROUNDS; r++)
            tw = mix_columns(shift_rows(sub_bytes(tw, 0), 0), 0) ^ trk[r];
        tw = shift_rows(sub_bytes(tw, 0), 0) ^ trk[ROUNDS];
        for (int j = 0; j < it.bidx; j++)
        begin
            carry = tw[127];
            tw = tw << 1;
            if (carry) tw[7:0] ^= GF_POLY;
        end

        s = {it.hi, it.lo} ^ tw ^ drk[ROUNDS];
        s = sub_bytes(shift_rows(s, 1), 1);
        for (int r = ROUNDS - 1; r >= 1; r--)
            s = sub_bytes(shift_rows(mix_columns(s ^ drk[r], 1), 1), 1);
        return s ^ drk[0] ^ tw;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Input driver: takes the next block when the previous transaction is done.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && in_stall))
            begin
                if (in_valid)
                    expected_plain.insert(expected_plain.size(),
                                          xts_plaintext('{sector, block_pos,
                                                          cipher_low, cipher_high}));
                if (gap_cnt > 0)
                begin
                    gap_cnt <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_blocks.size() > 0)
                begin
                    cipher_item_t it;
                    it = pending_blocks.pop_front();
                    sector <= it.sector;
                    block_pos <= it.bidx;
                    cipher_low <= it.lo;
                    cipher_high <= it.hi;
                    in_valid <= 1'b1;
                    gap_cnt <= idle_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result transaction against the oldest expectation and drives out_stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_plain.size() == 0)
                begin
                    $error("unexpected result plain_low=%h plain_high=%h",
                           plain_low, plain_high);
                    fails++;
                end
                else
                begin
                    blk_t e;
                    e = expected_plain.pop_front();
                    if (plain_low !== e[63:0])
                    begin
                        $error("plain_low expected %h actual %h", e[63:0], plain_low);
                        fails++;
                    end
                    if (plain_high !== e[127:64])
                    begin
                        $error("plain_high expected %h actual %h", e[127:64], plain_high);
                        fails++;
                    end
                end
                n_done++;
            end
            if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= rx_hold;
                stall_cnt <= ($urandom_range(0, 3) == 0) ? idle_length() : 0;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering blocks.
    initial
    begin
        while (n_done < 400) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        if (idx < REG_DK0 + 4) data_key[idx - REG_DK0] = value;
        else tweak_key[idx - (REG_TK3 - 3)] = value;
    endtask

    task automatic load_keys(key_words_t dk, key_words_t tk);
        for (int i = 0; i < 4; i++) write_reg(REG_DK0 + 3'(i), dk[i]);
        for (int i = 0; i < 4; i++) write_reg(REG_TK3 - 3'(3 - i), tk[i]);
    endtask

    task automatic queue_block(logic [31:0] sec, logic [4:0] bidx, logic [63:0] lo,
                               logic [63:0] hi);
        cipher_item_t it;
        it = '{sec, bidx, lo, hi};
        pending_blocks.insert(pending_blocks.size(), it);
        n_sent++;
    endtask

    // Sender pause: wait for every result, then let the block settle.
    task automatic drain();
        while (n_done < n_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        key_words_t dk;
        key_words_t tk;
        logic [31:0] sec;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        data_key = '{default: 64'h0};
        tweak_key = '{default: 64'h0};
        for (int i = 0; i < 256; i++) inv_sb[SBOX[i]] = 8'(i);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Keys at their reset value: sector and index extremes.
        queue_block(32'h0, 5'd0, 64'h0, 64'h0);
        queue_block(32'hFFFFFFFF, 5'd0, '1, '1);
        queue_block(32'h80000000, 5'd31, 64'h0, '1);
        queue_block(32'h7FFFFFFF, 5'd31, '1, 64'h0);
        queue_block(32'h1, 5'd1, rand64(), rand64());
        queue_block(32'h80000000, 5'd0, rand64(), rand64());
        queue_block(32'h7FFFFFFF, 5'd1, rand64(), rand64());
        queue_block(32'hFFFFFFFF, 5'd31, rand64(), rand64());
        drain();

        // All-ones keys, then zero data key with random tweak key.
        dk = '{default: '1};
        tk = '{default: '1};
        load_keys(dk, tk);
        queue_block(32'h0, 5'd31, 64'h0, 64'h0);
        queue_block(32'hFFFFFFFF, 5'd31, '1, '1);
        queue_block(32'h80000000, 5'd0, rand64(), rand64());
        queue_block(32'h7FFFFFFF, 5'd16, rand64(), rand64());
        queue_block(32'h0, 5'd0, rand64(), rand64());
        queue_block(32'hFFFFFFFF, 5'd1, rand64(), rand64());
        drain();

        dk = '{default: 64'h0};
        tk = '{rand64(), rand64(), rand64(), rand64()};
        load_keys(dk, tk);
        for (int i = 0; i < 6; i++) queue_block($urandom(), 5'($urandom()), pick64(), pick64());
        drain();

        // Random phases with fresh keys; one phase runs with no idling.
        for (int p = 0; p < 5; p++)
        begin
            dk = '{rand64(), rand64(), rand64(), rand64()};
            tk = '{rand64(), rand64(), rand64(), rand64()};
            load_keys(dk, tk);
            no_idle <= (p == 2);
            for (int i = 0; i < 336; i++)
            begin
                case ($urandom_range(0, 7))
                    0: sec = 32'h80000000;
                    1: sec = 32'h7FFFFFFF;
                    2: sec = $urandom_range(0, 255);
                    default: sec = $urandom();
                endcase
                queue_block(sec, 5'($urandom()), pick64(), pick64());
            end
            drain();
        end

        if (fails == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
